// File: rtl/prrq_pkg.sv
// prrq_pkg: shared types and constants for the priority round-robin run queue
// no dependencies; imported by priority_round_robin_run_queue, prrq_checker, tb

package prrq_pkg;

    localparam int NUM_TASKS_DEF = 32;
    localparam int MAX_PRIO_DEF  = 7;

    localparam int FUNC_W   = 2;
    localparam int TID_W    = 5;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;

    localparam int S_FIELDS_W = FUNC_W + TID_W + PRIO_W;
    localparam int M_FIELDS_W = STATUS_W + TID_W + 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        OP_ENQUEUE       = 2'd0,
        OP_DEQUEUE       = 2'd1,
        OP_DETACH        = 2'd2,
        OP_PREEMPT_CHECK = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 2'd0,
        ST_EMPTY          = 2'd1,
        ST_ALREADY_QUEUED = 2'd2
    } status_t;

endpackage

// File: rtl/priority_round_robin_run_queue.sv
// priority_round_robin_run_queue: per-level doubly linked fifos over a task pool
// depends on prrq_pkg
//
// usage: each word on the s_axis channel is one request (enqueue, dequeue,
// detach or preemption check); each request gives exactly one result word on
// the m_axis channel, in request order.
// a request is taken into an input register, then processed by the list
// logic, which updates the queue state and loads the result register.
// throughput: one request per cycle while m_axis_tready stays high; the list
// update writes link, level, head and tail files at most once each per cycle.
// s_axis_tready stays high while the input register is empty or moves on, so
// a waiting result does not stop the next request from being taken.
// when the receiver stalls, the result register holds, the input register
// fills, and s_axis_tready falls until m_axis_tready returns.
// reset empties every level and both registers; link, level, head and tail
// entries hold no reset value and are only read behind their valid bits.

module priority_round_robin_run_queue #(
    parameter int NUM_TASKS = prrq_pkg::NUM_TASKS_DEF,
    parameter int MAX_PRIO  = prrq_pkg::MAX_PRIO_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // func[1:0], task_id[6:2], priority_req[9:7]
    input  logic [prrq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[1:0], picked_task[6:2], picked_valid[7], preempt[8]
    output logic [prrq_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import prrq_pkg::*;

    // ids and priorities above the field range can never arrive
    localparam int POOL  = (NUM_TASKS < (1 << TID_W)) ? NUM_TASKS : (1 << TID_W);
    localparam int IDX_W = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int TOPL  = (MAX_PRIO < (1 << PRIO_W) - 1) ? MAX_PRIO : (1 << PRIO_W) - 1;
    localparam int LVLS  = TOPL + 1;
    localparam int LVL_W = (LVLS > 1) ? $clog2(LVLS) : 1;
    localparam logic [PRIO_W-1:0] TOP_PRIO = PRIO_W'(TOPL);

    // input register
    logic              in_valid_reg;
    logic [FUNC_W-1:0] in_func_reg;
    logic [TID_W-1:0]  in_tid_reg;
    logic [PRIO_W-1:0] in_prio_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [TID_W-1:0]    out_picked_reg;
    logic                out_picked_valid_reg;
    logic                out_preempt_reg;

    // queue state
    logic [IDX_W-1:0] next_link_reg  [POOL];
    logic [IDX_W-1:0] prev_link_reg  [POOL];
    logic [LVL_W-1:0] task_level_reg [POOL];
    logic [IDX_W-1:0] level_head_reg [LVLS];
    logic [IDX_W-1:0] level_tail_reg [LVLS];
    logic [POOL-1:0]  is_queued_reg;
    logic [POOL-1:0]  is_queued_next;
    logic [LVLS-1:0]  level_nonempty_reg;
    logic [LVLS-1:0]  level_nonempty_next;

    logic proc;
    op_t  op;

    logic             tid_ok;
    logic [IDX_W-1:0] tid_idx;
    logic             hi_found;
    logic [LVL_W-1:0] hi_lvl;
    logic [LVL_W-1:0] enq_lvl;
    logic [PRIO_W-1:0] sat_prio;

    logic             do_enq;
    logic             do_unlink;
    logic [IDX_W-1:0] u_task;
    logic [LVL_W-1:0] u_lvl;
    logic [IDX_W-1:0] u_nx;
    logic [IDX_W-1:0] u_pv;
    logic             at_head;
    logic             at_tail;

    logic             nl_we, pl_we, tl_we, hd_we, tt_we;
    logic [IDX_W-1:0] nl_addr, nl_data, pl_addr, pl_data, hd_data, tt_data;
    logic [LVL_W-1:0] hd_addr, tt_addr;

    logic [STATUS_W-1:0] res_status;
    logic [TID_W-1:0]    res_picked;
    logic                res_picked_valid;
    logic                res_preempt;

    assign proc          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign op            = op_t'(in_func_reg);

    assign tid_ok   = (int'(in_tid_reg) < NUM_TASKS);
    assign tid_idx  = in_tid_reg[IDX_W-1:0];
    assign sat_prio = (in_prio_reg > TOP_PRIO) ? TOP_PRIO : in_prio_reg;
    assign enq_lvl  = sat_prio[LVL_W-1:0];

    // highest non-empty level
    always_comb begin
        hi_found = 1'b0;
        hi_lvl   = '0;
        for (int l = 0; l < LVLS; l++) begin
            if (level_nonempty_reg[l]) begin
                hi_found = 1'b1;
                hi_lvl   = LVL_W'(l);
            end
        end
    end

    always_comb begin
        res_preempt = 1'b0;
        for (int l = 0; l < LVLS; l++) begin
            if (level_nonempty_reg[l] && (l > int'(in_prio_reg))) begin
                res_preempt = 1'b1;
            end
        end
        if (op != OP_PREEMPT_CHECK) begin
            res_preempt = 1'b0;
        end
    end

    // unlink target: head of the top level on dequeue, else the given task
    assign u_task  = (op == OP_DEQUEUE) ? level_head_reg[hi_lvl] : tid_idx;
    assign u_lvl   = (op == OP_DEQUEUE) ? hi_lvl : task_level_reg[tid_idx];
    assign u_nx    = next_link_reg[u_task];
    assign u_pv    = prev_link_reg[u_task];
    assign at_head = (level_head_reg[u_lvl] == u_task);
    assign at_tail = (level_tail_reg[u_lvl] == u_task);

    assign do_enq    = (op == OP_ENQUEUE) && tid_ok && !is_queued_reg[tid_idx];
    assign do_unlink = (op == OP_DEQUEUE) ? hi_found
                     : ((op == OP_DETACH) && tid_ok && is_queued_reg[tid_idx]);

    always_comb begin
        nl_we   = 1'b0;
        nl_addr = level_tail_reg[enq_lvl];
        nl_data = tid_idx;
        pl_we   = 1'b0;
        pl_addr = tid_idx;
        pl_data = level_tail_reg[enq_lvl];
        tl_we   = 1'b0;
        hd_we   = 1'b0;
        hd_addr = enq_lvl;
        hd_data = tid_idx;
        tt_we   = 1'b0;
        tt_addr = enq_lvl;
        tt_data = tid_idx;
        is_queued_next      = is_queued_reg;
        level_nonempty_next = level_nonempty_reg;
        if (proc && do_enq) begin
            tl_we = 1'b1;
            tt_we = 1'b1;
            is_queued_next[tid_idx] = 1'b1;
            if (level_nonempty_reg[enq_lvl]) begin
                nl_we = 1'b1;
                pl_we = 1'b1;
            end else begin
                hd_we = 1'b1;
                level_nonempty_next[enq_lvl] = 1'b1;
            end
        end else if (proc && do_unlink) begin
            is_queued_next[u_task] = 1'b0;
            hd_addr = u_lvl;
            hd_data = u_nx;
            tt_addr = u_lvl;
            tt_data = u_pv;
            nl_addr = u_pv;
            nl_data = u_nx;
            pl_addr = u_nx;
            pl_data = u_pv;
            priority if (at_head && at_tail) begin
                level_nonempty_next[u_lvl] = 1'b0;
            end else if (at_head) begin
                hd_we = 1'b1;
            end else if (at_tail) begin
                tt_we = 1'b1;
            end else begin
                nl_we = 1'b1;
                pl_we = 1'b1;
            end
        end
    end

    always_comb begin
        res_status       = ST_OK;
        res_picked       = '0;
        res_picked_valid = 1'b0;
        unique case (op)
            OP_ENQUEUE: begin
                if (tid_ok && is_queued_reg[tid_idx]) begin
                    res_status = ST_ALREADY_QUEUED;
                end
            end
            OP_DEQUEUE: begin
                if (hi_found) begin
                    res_picked       = TID_W'(u_task);
                    res_picked_valid = 1'b1;
                end else begin
                    res_status = ST_EMPTY;
                end
            end
            OP_DETACH, OP_PREEMPT_CHECK: begin
                res_status = ST_OK;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            is_queued_reg      <= '0;
            level_nonempty_reg <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (proc) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            is_queued_reg      <= is_queued_next;
            level_nonempty_reg <= level_nonempty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_func_reg <= s_axis_tdata[FUNC_W-1:0];
            in_tid_reg  <= s_axis_tdata[FUNC_W +: TID_W];
            in_prio_reg <= s_axis_tdata[FUNC_W+TID_W +: PRIO_W];
        end
        if (proc) begin
            out_status_reg       <= res_status;
            out_picked_reg       <= res_picked;
            out_picked_valid_reg <= res_picked_valid;
            out_preempt_reg      <= res_preempt;
        end
    end

    // list storage, one write port each
    always_ff @(posedge aclk) begin
        if (nl_we) begin
            next_link_reg[nl_addr] <= nl_data;
        end
        if (pl_we) begin
            prev_link_reg[pl_addr] <= pl_data;
        end
        if (tl_we) begin
            task_level_reg[tid_idx] <= enq_lvl;
        end
        if (hd_we) begin
            level_head_reg[hd_addr] <= hd_data;
        end
        if (tt_we) begin
            level_tail_reg[tt_addr] <= tt_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_preempt_reg, out_picked_valid_reg,
                                       out_picked_reg, out_status_reg});

    // some task is queued exactly when some level is non-empty
    a_queued_vs_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        (|is_queued_reg) == (|level_nonempty_reg))
        else $error("queued tasks and non-empty levels disagree");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (is_queued_reg == '0) && (level_nonempty_reg == '0))
        else $error("queues not empty after reset");

    a_unlink_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && do_unlink && !do_enq |=> !is_queued_reg[$past(u_task)])
        else $error("unlinked task still marked queued");

    a_pick_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_picked_valid_reg |->
            (out_status_reg == ST_OK) && !out_preempt_reg)
        else $error("picked task with inconsistent result fields");

    a_enq_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && do_enq |=> level_nonempty_reg[$past(enq_lvl)])
        else $error("enqueue left its level empty");

endmodule

// File: dv/prrq_checker.sv
`timescale 1ns / 100ps
// prrq_checker: watches both stream channels of the run queue, keeps its own copy
// of the per-level task lists and checks every result word against it
// depends on prrq_pkg

module prrq_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [prrq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [prrq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                             fail_count,
    output int                             pending_count
);
    import prrq_pkg::*;

    localparam int NUM_TASKS = NUM_TASKS_DEF;
    localparam int MAX_PRIO  = MAX_PRIO_DEF;
    localparam int NLEVELS   = MAX_PRIO + 1;

    typedef struct packed {
        logic                preempt;
        logic                picked_valid;
        logic [TID_W-1:0]    picked;
        logic [STATUS_W-1:0] status;
    } run_result_t;

    logic [TID_W-1:0]  next_of  [NUM_TASKS];
    logic [TID_W-1:0]  prev_of  [NUM_TASKS];
    logic              queued   [NUM_TASKS];
    logic [PRIO_W-1:0] level_of [NUM_TASKS];
    logic [TID_W-1:0]  head_of  [NLEVELS];
    logic [TID_W-1:0]  tail_of  [NLEVELS];
    logic              level_busy [NLEVELS];

    run_result_t awaited_results [$];
    int          mismatches = 0;

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < 20)
            $display("%0t: run queue result mismatch on %s: got %0d, want %0d",
                     $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic unlink_task(input logic [TID_W-1:0] t);
        logic [PRIO_W-1:0] lv;
        logic [TID_W-1:0]  nx;
        logic [TID_W-1:0]  pv;
        lv = level_of[t];
        nx = next_of[t];
        pv = prev_of[t];
        if (head_of[lv] == t && tail_of[lv] == t) begin
            level_busy[lv] = 1'b0;
        end else if (head_of[lv] == t) begin
            head_of[lv] = nx;
        end else if (tail_of[lv] == t) begin
            tail_of[lv] = pv;
        end else begin
            next_of[pv] = nx;
            prev_of[nx] = pv;
        end
        queued[t] = 1'b0;
    endtask

    task automatic predict_request(input logic [S_TDATA_W-1:0] word, output run_result_t r);
        op_t               op;
        logic [TID_W-1:0]  t;
        logic [PRIO_W-1:0] p;
        logic [TID_W-1:0]  h;
        int                lv;
        op = op_t'(word[FUNC_W-1:0]);
        t  = word[FUNC_W +: TID_W];
        p  = word[FUNC_W+TID_W +: PRIO_W];
        r  = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQUEUE: begin
                if (int'(t) < NUM_TASKS) begin
                    if (queued[t]) begin
                        r.status = ST_ALREADY_QUEUED;
                    end else begin
                        lv = (int'(p) > MAX_PRIO) ? MAX_PRIO : int'(p);
                        level_of[t] = PRIO_W'(lv);
                        queued[t]   = 1'b1;
                        if (level_busy[lv]) begin
                            next_of[tail_of[lv]] = t;
                            prev_of[t]           = tail_of[lv];
                            tail_of[lv]          = t;
                        end else begin
                            head_of[lv]    = t;
                            tail_of[lv]    = t;
                            level_busy[lv] = 1'b1;
                        end
                    end
                end
            end
            OP_DEQUEUE: begin
                r.status = ST_EMPTY;
                for (lv = MAX_PRIO; lv >= 0 && !r.picked_valid; lv--) begin
                    if (level_busy[lv]) begin
                        h = head_of[lv];
                        unlink_task(h);
                        r.picked       = h;
                        r.picked_valid = 1'b1;
                        r.status       = ST_OK;
                    end
                end
            end
            OP_DETACH: begin
                if (int'(t) < NUM_TASKS && queued[t])
                    unlink_task(t);
            end
            default: begin
                for (lv = int'(p) + 1; lv <= MAX_PRIO; lv++)
                    if (level_busy[lv])
                        r.preempt = 1'b1;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        run_result_t got;
        run_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_TASKS; i++)
                queued[i] = 1'b0;
            for (int i = 0; i < NLEVELS; i++)
                level_busy[i] = 1'b0;
            awaited_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = run_result_t'(m_axis_tdata[M_FIELDS_W-1:0]);
                if (m_axis_tdata[M_TDATA_W-1:M_FIELDS_W] !== '0)
                    report_mismatch("padding", int'(m_axis_tdata[M_TDATA_W-1:M_FIELDS_W]), 0);
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected word", int'(got), -1);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.picked !== want.picked)
                        report_mismatch("picked_task", int'(got.picked), int'(want.picked));
                    if (got.picked_valid !== want.picked_valid)
                        report_mismatch("picked_valid", int'(got.picked_valid),
                                        int'(want.picked_valid));
                    if (got.preempt !== want.preempt)
                        report_mismatch("preempt", int'(got.preempt), int'(want.preempt));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(s_axis_tdata, want);
                awaited_results.push_back(want);
            end
        end
        pending_count <= awaited_results.size();
        fail_count    <= mismatches;
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for the priority round-robin run queue
// depends on prrq_pkg, priority_round_robin_run_queue and prrq_checker

module tb;
    import prrq_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 80;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    int                   fail_count;
    int                   pending_count;

    bit calm        = 1'b0;
    bit hold_active = 1'b0;
    bit hold_done   = 1'b0;
    int sent_count  = 0;
    int op_count [4];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    priority_round_robin_run_queue uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    prrq_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    task automatic issue(input op_t op, input logic [TID_W-1:0] t, input logic [PRIO_W-1:0] p);
        int gap;
        s_axis_tdata  <= {{(S_TDATA_W-S_FIELDS_W){1'b0}}, p, t, op};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        sent_count++;
        op_count[op]++;
        gap = (calm || hold_active || $urandom_range(0, 99) >= 30) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
    endtask

    function automatic op_t pick_op(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 55) return OP_ENQUEUE;
            if (r < 72) return OP_DEQUEUE;
            if (r < 88) return OP_DETACH;
            return OP_PREEMPT_CHECK;
        end
        if (r < 25) return OP_ENQUEUE;
        if (r < 65) return OP_DEQUEUE;
        if (r < 85) return OP_DETACH;
        return OP_PREEMPT_CHECK;
    endfunction

    // receiver: random stalls, one long hold once the sender is well under way
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done     = 1'b1;
                hold_active   = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active   = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0 && !calm) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
                if (!calm && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        bit                filling;
        bit                narrow;
        int                base;
        op_t               op;
        logic [PRIO_W-1:0] p;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queues, idle detach, saturation of the preemption check
        issue(OP_DEQUEUE, 5'd0, 3'd0);
        issue(OP_PREEMPT_CHECK, 5'd0, 3'd0);
        issue(OP_DETACH, 5'd5, 3'd0);
        issue(OP_ENQUEUE, 5'd0, 3'd0);
        issue(OP_ENQUEUE, 5'd31, 3'd7);
        issue(OP_ENQUEUE, 5'd31, 3'd3);
        issue(OP_PREEMPT_CHECK, 5'd31, 3'd7);
        issue(OP_PREEMPT_CHECK, 5'd0, 3'd6);
        issue(OP_PREEMPT_CHECK, 5'd0, 3'd0);
        // one level with four tasks, then unlink middle, head, tail and sole entry
        issue(OP_ENQUEUE, 5'd10, 3'd4);
        issue(OP_ENQUEUE, 5'd11, 3'd4);
        issue(OP_ENQUEUE, 5'd12, 3'd4);
        issue(OP_ENQUEUE, 5'd13, 3'd4);
        issue(OP_DETACH, 5'd12, 3'd0);
        issue(OP_DETACH, 5'd10, 3'd0);
        issue(OP_DETACH, 5'd13, 3'd0);
        issue(OP_DETACH, 5'd11, 3'd0);
        issue(OP_DEQUEUE, 5'd0, 3'd0);
        issue(OP_PREEMPT_CHECK, 5'd0, 3'd0);
        issue(OP_DEQUEUE, 5'd0, 3'd0);
        issue(OP_DEQUEUE, 5'd0, 3'd0);
        issue(OP_ENQUEUE, 5'd21, 3'd5);
        issue(OP_ENQUEUE, 5'd10, 3'd2);
        issue(OP_DEQUEUE, 5'd0, 3'd0);
        issue(OP_DEQUEUE, 5'd0, 3'd0);
        drain_wait();

        filling = 1'b1;
        narrow  = 1'b0;
        base    = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                filling = ($urandom_range(0, 1) == 1);
                narrow  = ($urandom_range(0, 2) == 0);
                base    = $urandom_range(0, 6);
                calm    = ($urandom_range(0, 3) == 0);
            end
            if (n == 400) begin
                calm = 1'b0;
                drain_wait();
            end
            op = pick_op(filling);
            p  = narrow ? PRIO_W'(base + $urandom_range(0, 1)) : PRIO_W'($urandom_range(0, 7));
            issue(op, TID_W'($urandom_range(0, 31)), p);
        end
        calm = 1'b0;
        drain_wait();
        repeat (10) @(posedge aclk);

        $display("run covered %0d requests: %0d enqueue, %0d dequeue, %0d detach, %0d preempt",
                 sent_count, op_count[OP_ENQUEUE], op_count[OP_DEQUEUE],
                 op_count[OP_DETACH], op_count[OP_PREEMPT_CHECK]);
        $display("with random stalls on both sides and a %0d cycle receiver hold",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/prrq_pkg.sv
rtl/priority_round_robin_run_queue.sv
dv/prrq_checker.sv
dv/tb.sv
